// ----- hw/rtl/vec3_pkg.sv -----
// Shared types and constants of the three-component vector ALU.
package vec3_pkg;

	localparam int FIELD_BITS = 32;
	localparam int KIND_BITS  = 3;

	typedef enum logic [KIND_BITS-1:0] {
		K_ADD       = 3'd0,
		K_SUB       = 3'd1,
		K_SCALE     = 3'd2,
		K_DOT       = 3'd3,
		K_CROSS     = 3'd4,
		K_NORM      = 3'd5,
		K_NORMALIZE = 3'd6
	} kind_t;

endpackage

// ----- hw/rtl/vec3_in_if.sv -----
// Operand channel: valid, ready and one beat of two vectors, a scalar and an operation.
interface vec3_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [vec3_pkg::KIND_BITS-1:0]         kind;
	logic signed [vec3_pkg::FIELD_BITS-1:0] u_x;
	logic signed [vec3_pkg::FIELD_BITS-1:0] u_y;
	logic signed [vec3_pkg::FIELD_BITS-1:0] u_z;
	logic signed [vec3_pkg::FIELD_BITS-1:0] v_x;
	logic signed [vec3_pkg::FIELD_BITS-1:0] v_y;
	logic signed [vec3_pkg::FIELD_BITS-1:0] v_z;
	logic signed [vec3_pkg::FIELD_BITS-1:0] scale_factor;

	modport source (output valid, kind, u_x, u_y, u_z, v_x, v_y, v_z, scale_factor,
		input ready);
	modport sink (input valid, kind, u_x, u_y, u_z, v_x, v_y, v_z, scale_factor,
		output ready);
endinterface

// ----- hw/rtl/vec3_out_if.sv -----
// Result channel: valid, ready and one beat of a vector, a scalar and two flags.
interface vec3_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [vec3_pkg::FIELD_BITS-1:0] r_x;
	logic signed [vec3_pkg::FIELD_BITS-1:0] r_y;
	logic signed [vec3_pkg::FIELD_BITS-1:0] r_z;
	logic signed [vec3_pkg::FIELD_BITS-1:0] scalar_out;
	logic                                   saturated;
	logic                                   zero_divide;

	modport source (output valid, r_x, r_y, r_z, scalar_out, saturated, zero_divide,
		input ready);
	modport sink (input valid, r_x, r_y, r_z, scalar_out, saturated, zero_divide,
		output ready);
endinterface

// ----- hw/rtl/vec3_prod.sv -----
// Operand selection, product stage and sum stage of the vector ALU.
module vec3_prod #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  vec3_pkg::kind_t       kind,
	input  logic signed [W-1:0]   u [3],
	input  logic signed [W-1:0]   v [3],
	input  logic signed [W-1:0]   k,
	output logic                  vld_s3,
	output vec3_pkg::kind_t       kind_s3,
	output logic signed [2*W+1:0] sum_s3 [3],
	output logic signed [2*W+1:0] tot_s3,
	output logic signed [W:0]     as_s3 [3],
	output logic signed [W-1:0]   u_s3 [3]
);
	localparam int E = 2*W+2;

	logic signed [W-1:0]   a_c [3];
	logic signed [W-1:0]   b_c [3];
	logic signed [W-1:0]   c_c [3];
	logic signed [W-1:0]   d_c [3];

	logic                  vld_s1;
	vec3_pkg::kind_t       kind_s1;
	logic signed [W-1:0]   a_s1 [3];
	logic signed [W-1:0]   b_s1 [3];
	logic signed [W-1:0]   c_s1 [3];
	logic signed [W-1:0]   d_s1 [3];
	logic signed [W-1:0]   u_s1 [3];
	logic signed [W-1:0]   v_s1 [3];

	logic                  vld_s2;
	vec3_pkg::kind_t       kind_s2;
	logic signed [2*W-1:0] p_s2 [3];
	logic signed [2*W-1:0] q_s2 [3];
	logic signed [W:0]     as_s2 [3];
	logic signed [W-1:0]   u_s2 [3];

	for (genvar i = 0; i < 3; i++) begin : g_sel
		localparam int IA = (i + 1) % 3;
		localparam int IB = (i + 2) % 3;
		always_comb begin
			a_c[i] = u[i];
			b_c[i] = '0;
			c_c[i] = '0;
			d_c[i] = '0;
			case (kind)
				vec3_pkg::K_SCALE: b_c[i] = k;
				vec3_pkg::K_DOT: b_c[i] = v[i];
				vec3_pkg::K_NORM, vec3_pkg::K_NORMALIZE: b_c[i] = u[i];
				vec3_pkg::K_CROSS: begin
					a_c[i] = u[IA];
					b_c[i] = v[IB];
					c_c[i] = u[IB];
					d_c[i] = v[IA];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= a_c[i];
				b_s1[i]  <= b_c[i];
				c_s1[i]  <= c_c[i];
				d_s1[i]  <= d_c[i];
				u_s1[i]  <= u[i];
				v_s1[i]  <= v[i];
				p_s2[i]  <= a_s1[i] * b_s1[i];
				q_s2[i]  <= c_s1[i] * d_s1[i];
				as_s2[i] <= (kind_s1 == vec3_pkg::K_SUB) ?
					(W+1)'(u_s1[i]) - (W+1)'(v_s1[i]) :
					(W+1)'(u_s1[i]) + (W+1)'(v_s1[i]);
				u_s2[i]  <= u_s1[i];
				sum_s3[i] <= E'(p_s2[i]) - E'(q_s2[i]);
				as_s3[i]  <= as_s2[i];
				u_s3[i]   <= u_s2[i];
			end
			tot_s3 <= E'(p_s2[0]) + E'(p_s2[1]) + E'(p_s2[2]);
		end
	end
endmodule

// ----- hw/rtl/vec3_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module vec3_sqrt #(
	parameter int W  = 32,
	parameter int SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*W-1:0]  rad,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [W-1:0]    root,
	output logic [SW-1:0]   out_side
);
	logic           vld_s  [W+1];
	logic [2*W-1:0] rad_s  [W+1];
	logic [W+2:0]   rem_s  [W+1];
	logic [W-1:0]   root_s [W+1];
	logic [SW-1:0]  side_s [W+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < W; j++) begin : g_stage
		logic [W+2:0] t;
		logic [W+2:0] trial;
		logic         ge;
		assign t     = {rem_s[j][W:0], rad_s[j][2*W-1 -: 2]};
		assign trial = {1'b0, root_s[j], 2'b01};
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j+1]  <= rad_s[j] << 2;
				rem_s[j+1]  <= ge ? t - trial : t;
				root_s[j+1] <= {root_s[j][W-2:0], ge};
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = vld_s[W];
	assign root      = root_s[W];
	assign out_side  = side_s[W];
endmodule

// ----- hw/rtl/vec3_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
module vec3_div #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [W+F-1:0]    num,
	input  logic [W-1:0]      den,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	output logic [W+F-1:0]    quo,
	output logic [SW-1:0]     out_side
);
	localparam int N = W + F;

	logic          vld_s  [N+1];
	logic [N-1:0]  nq_s   [N+1];
	logic [W-1:0]  rem_s  [N+1];
	logic [W-1:0]  den_s  [N+1];
	logic [SW-1:0] side_s [N+1];

	assign vld_s[0]  = in_valid;
	assign nq_s[0]   = num;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [W:0] t;
		logic [W:0] diff;
		logic       ge;
		assign t    = {rem_s[j], nq_s[j][N-1]};
		assign ge   = t >= {1'b0, den_s[j]};
		assign diff = t - {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[j+1]   <= {nq_s[j][N-2:0], ge};
				rem_s[j+1]  <= ge ? diff[W-1:0] : t[W-1:0];
				den_s[j+1]  <= den_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign quo       = nq_s[N];
	assign out_side  = side_s[N];
endmodule

// ----- hw/rtl/vec3_vector_alu.sv -----
// Three-component fixed-point vector ALU, top level.
//
// Operand beats arrive on in_ch and carry two vectors u and v, a scalar
// scale_factor and an operation kind. Every beat yields one result beat
// on out_ch: a vector r, a scalar, a saturation flag and a divide flag.
// Four stages select operands, multiply, sum and round, then WORD_BITS
// stages of the square root and WORD_BITS+FRAC_BITS stages of the three
// dividers, then the output register.
// Throughput is one beat per cycle unless the output stalls; the deepest
// chains are the one-bit square root and division steps and the 32 by 32
// products. Reset clears all valid bits, so the pipeline comes up empty.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and in_ch.ready drops; nothing is lost or repeated.
// Empty slots move on freely, so in_ch.ready stays high while the output
// register is empty.
module vec3_vector_alu #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	vec3_in_if.sink    in_ch,
	vec3_out_if.source out_ch
);
	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int E   = 2*W + 2;
	localparam int N   = W + F;
	localparam int X   = (E + 1 > N + 2) ? E + 1 : N + 2;
	localparam int KB  = vec3_pkg::KIND_BITS;
	localparam int SW1 = KB + 7*W + 4;
	localparam int SW2 = KB + 5*W + 2;
	localparam logic signed [E:0] RND_HALF = (E+1)'(1) << (F - 1);

	function automatic logic [W:0] sat_x(input logic signed [X-1:0] x);
		logic hi_ones;
		logic hi_zero;
		hi_ones = &x[X-1:W-1];
		hi_zero = ~|x[X-1:W-1];
		if (hi_ones || hi_zero) return {1'b0, x[W-1:0]};
		else if (x[X-1]) return {1'b1, 1'b1, {(W-1){1'b0}}};
		else return {1'b1, 1'b0, {(W-1){1'b1}}};
	endfunction

	function automatic logic signed [X-1:0] rnd(input logic signed [E-1:0] s);
		logic signed [E:0] t;
		t = (E+1)'(s) + RND_HALF;
		return X'(t >>> F);
	endfunction

	logic                  en;
	logic                  o_valid_q;
	logic [W-1:0]          o_r_q [3];
	logic [W-1:0]          o_sc_q;
	logic                  o_sat_q;
	logic                  o_zd_q;

	logic signed [W-1:0]   u_in [3];
	logic signed [W-1:0]   v_in [3];
	logic signed [W-1:0]   k_in;

	logic                  vld_s3;
	vec3_pkg::kind_t       kind_s3;
	logic signed [E-1:0]   sum_s3 [3];
	logic signed [E-1:0]   tot_s3;
	logic signed [W:0]     as_s3 [3];
	logic signed [W-1:0]   u_s3 [3];

	logic [W-1:0]          r_c [3];
	logic [W-1:0]          sc_c;
	logic                  sat_c;
	logic [W-1:0]          mag_c [3];
	logic [W:0]            rr_c [3];
	logic [W:0]            ra_c [3];
	logic [W:0]            rt_c;

	logic                  vld_s4;
	logic [SW1-1:0]        side_s4;
	logic [2*W-1:0]        rad_s4;

	logic                  sq_valid;
	logic [W-1:0]          sq_root;
	logic [SW1-1:0]        sq_side;
	logic [KB-1:0]         sq_kind;
	logic [W-1:0]          sq_r [3];
	logic [W-1:0]          sq_sc;
	logic                  sq_sat;
	logic                  sq_neg [3];
	logic [W-1:0]          sq_mag [3];

	logic                  dv_valid [3];
	logic [N-1:0]          dv_quo [3];
	logic [SW2-1:0]        dv_side0;
	logic                  dv_neg1;
	logic                  dv_neg2;
	logic [KB-1:0]         f_kind;
	logic [W-1:0]          f_r_in [3];
	logic [W-1:0]          f_sc_in;
	logic                  f_sat_in;
	logic                  f_neg [3];
	logic [W-1:0]          f_root;
	logic [W-1:0]          f_r [3];
	logic [W-1:0]          f_sc;
	logic                  f_sat;
	logic                  f_zd;
	logic [W:0]            f_sat_root;
	logic [W:0]            f_sat_q [3];

	assign en = !o_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	assign u_in[0] = W'($unsigned(in_ch.u_x));
	assign u_in[1] = W'($unsigned(in_ch.u_y));
	assign u_in[2] = W'($unsigned(in_ch.u_z));
	assign v_in[0] = W'($unsigned(in_ch.v_x));
	assign v_in[1] = W'($unsigned(in_ch.v_y));
	assign v_in[2] = W'($unsigned(in_ch.v_z));
	assign k_in    = W'($unsigned(in_ch.scale_factor));

	vec3_prod #(.W(W)) u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_ch.valid),
		.kind     (vec3_pkg::kind_t'(in_ch.kind)),
		.u        (u_in),
		.v        (v_in),
		.k        (k_in),
		.vld_s3   (vld_s3),
		.kind_s3  (kind_s3),
		.sum_s3   (sum_s3),
		.tot_s3   (tot_s3),
		.as_s3    (as_s3),
		.u_s3     (u_s3)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rr_c[i]  = sat_x(rnd(sum_s3[i]));
			ra_c[i]  = sat_x(X'(as_s3[i]));
			mag_c[i] = u_s3[i][W-1] ? W'(-u_s3[i]) : W'(u_s3[i]);
			r_c[i]   = '0;
		end
		rt_c  = sat_x(rnd(tot_s3));
		sc_c  = '0;
		sat_c = 1'b0;
		case (kind_s3)
			vec3_pkg::K_ADD, vec3_pkg::K_SUB: begin
				for (int i = 0; i < 3; i++) r_c[i] = ra_c[i][W-1:0];
				sat_c = ra_c[0][W] | ra_c[1][W] | ra_c[2][W];
			end
			vec3_pkg::K_SCALE, vec3_pkg::K_CROSS: begin
				for (int i = 0; i < 3; i++) r_c[i] = rr_c[i][W-1:0];
				sat_c = rr_c[0][W] | rr_c[1][W] | rr_c[2][W];
			end
			vec3_pkg::K_DOT: begin
				sc_c  = rt_c[W-1:0];
				sat_c = rt_c[W];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= {kind_s3, r_c[0], r_c[1], r_c[2], sc_c, sat_c,
				u_s3[0][W-1], u_s3[1][W-1], u_s3[2][W-1], mag_c[0], mag_c[1], mag_c[2]};
			rad_s4  <= tot_s3[2*W-1:0];
		end
	end

	vec3_sqrt #(.W(W), .SW(SW1)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s4),
		.rad       (rad_s4),
		.in_side   (side_s4),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	assign {sq_kind, sq_r[0], sq_r[1], sq_r[2], sq_sc, sq_sat,
		sq_neg[0], sq_neg[1], sq_neg[2], sq_mag[0], sq_mag[1], sq_mag[2]} = sq_side;

	vec3_div #(.W(W), .F(F), .SW(SW2)) u_div0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.num       ({sq_mag[0], {F{1'b0}}}),
		.den       (sq_root),
		.in_side   ({sq_kind, sq_r[0], sq_r[1], sq_r[2], sq_sc, sq_sat, sq_neg[0],
			sq_root}),
		.out_valid (dv_valid[0]),
		.quo       (dv_quo[0]),
		.out_side  (dv_side0)
	);

	vec3_div #(.W(W), .F(F), .SW(1)) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.num       ({sq_mag[1], {F{1'b0}}}),
		.den       (sq_root),
		.in_side   (sq_neg[1]),
		.out_valid (dv_valid[1]),
		.quo       (dv_quo[1]),
		.out_side  (dv_neg1)
	);

	vec3_div #(.W(W), .F(F), .SW(1)) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.num       ({sq_mag[2], {F{1'b0}}}),
		.den       (sq_root),
		.in_side   (sq_neg[2]),
		.out_valid (dv_valid[2]),
		.quo       (dv_quo[2]),
		.out_side  (dv_neg2)
	);

	assign {f_kind, f_r_in[0], f_r_in[1], f_r_in[2], f_sc_in, f_sat_in, f_neg[0],
		f_root} = dv_side0;
	assign f_neg[1] = dv_neg1;
	assign f_neg[2] = dv_neg2;

	always_comb begin
		f_sat_root = sat_x(X'({1'b0, f_root}));
		for (int i = 0; i < 3; i++) begin
			f_sat_q[i] = f_neg[i] ? sat_x(-X'({1'b0, dv_quo[i]})) :
				sat_x(X'({1'b0, dv_quo[i]}));
			f_r[i] = f_r_in[i];
		end
		f_sc  = f_sc_in;
		f_sat = f_sat_in;
		f_zd  = 1'b0;
		case (vec3_pkg::kind_t'(f_kind))
			vec3_pkg::K_NORM: begin
				f_sc  = f_sat_root[W-1:0];
				f_sat = f_sat_root[W];
			end
			vec3_pkg::K_NORMALIZE: begin
				if (f_root == '0) begin
					f_zd = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) f_r[i] = f_sat_q[i][W-1:0];
					f_sat = f_sat_q[0][W] | f_sat_q[1][W] | f_sat_q[2][W];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (en) begin
			o_valid_q <= dv_valid[0] & dv_valid[1] & dv_valid[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) o_r_q[i] <= f_r[i];
			o_sc_q  <= f_sc;
			o_sat_q <= f_sat;
			o_zd_q  <= f_zd;
		end
	end

	assign out_ch.valid       = o_valid_q;
	assign out_ch.r_x         = vec3_pkg::FIELD_BITS'(o_r_q[0]);
	assign out_ch.r_y         = vec3_pkg::FIELD_BITS'(o_r_q[1]);
	assign out_ch.r_z         = vec3_pkg::FIELD_BITS'(o_r_q[2]);
	assign out_ch.scalar_out  = vec3_pkg::FIELD_BITS'(o_sc_q);
	assign out_ch.saturated   = o_sat_q;
	assign out_ch.zero_divide = o_zd_q;
endmodule

// ----- hw/rtl/vec3_chk.sv -----
// Port-level checker of the vector ALU and its bind to the top level.
module vec3_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] r_x,
	input logic [31:0] r_y,
	input logic [31:0] r_z,
	input logic [31:0] scalar_out,
	input logic        saturated,
	input logic        zero_divide
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result beat dropped while stalled.");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(r_x) && $stable(scalar_out) && $stable(saturated))
		else $error("Stalled result beat changed.");

	a_zd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_divide |-> r_x == '0 && r_y == '0 && r_z == '0 &&
			scalar_out == '0)
		else $error("Zero-length normalize returned a nonzero field.");

	a_zd_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_divide |-> !saturated)
		else $error("Zero-length normalize raised saturation.");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled with an empty output register.");
endmodule

bind vec3_vector_alu vec3_chk u_vec3_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.r_x         (out_ch.r_x),
	.r_y         (out_ch.r_y),
	.r_z         (out_ch.r_z),
	.scalar_out  (out_ch.scalar_out),
	.saturated   (out_ch.saturated),
	.zero_divide (out_ch.zero_divide)
);
